// File: rtl/apbc_pkg.sv
// Shared types and constants for the adaptive prefilter bypass controller.
package apbc_pkg;

    localparam int BLK_W  = 11;
    localparam int CNT_W  = 48;
    localparam int EVT_W  = 32;
    localparam int OBS_W  = 13;
    localparam int MODE_W = 3;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam int DEF_MAX_BLOCK_ROWS = 1024;
    localparam int DEF_PROBE_PERIOD   = 16;

    localparam logic [MODE_W-1:0] MODE_DIRECT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALWAYS    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PREFIX_20 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PREFIX_5  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PREFIX_2  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PERIODIC  = 3'd5;

    localparam logic REG_POLICY_MODE = 1'b0;

    typedef struct packed {
        logic             first_block;
        logic [BLK_W-1:0] block_rows;
        logic [BLK_W-1:0] block_passes;
        logic [BLK_W-1:0] block_hits;
    } t_in_beat;

    typedef struct packed {
        logic             filtered;
        logic             probed;
        logic             switched;
        logic             active_after;
        logic [CNT_W-1:0] total_filtered_rows;
        logic [CNT_W-1:0] total_verify_calls;
        logic [CNT_W-1:0] total_missed;
        logic [EVT_W-1:0] total_switches;
        logic [EVT_W-1:0] total_probes;
        logic [CNT_W-1:0] total_verified_hits;
    } t_out_beat;

    typedef struct packed {
        logic              restart;
        logic [MODE_W-1:0] mode;
    } t_seq_ctl;

endpackage

// File: rtl/apbc_step.sv
// Per-block decision logic and sequence state of the prefilter bypass controller.
module apbc_step
    import apbc_pkg::*;
#(
    parameter int MAX_BLOCK_ROWS = DEF_MAX_BLOCK_ROWS,
    parameter int PROBE_PERIOD   = DEF_PROBE_PERIOD
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_beat  i_beat,
    input  t_seq_ctl  i_ctl,
    output t_out_beat o_result
);

    localparam int PH_W = (PROBE_PERIOD > 1) ? $clog2(PROBE_PERIOD) : 1;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(PROBE_PERIOD - 1);
    localparam logic [PH_W-1:0] PH_ONE  = PH_W'(1 % PROBE_PERIOD);
    localparam logic [BLK_W-1:0] ROWS_CAP =
        (MAX_BLOCK_ROWS > (2**BLK_W - 1)) ? {BLK_W{1'b1}} : BLK_W'(MAX_BLOCK_ROWS);
    localparam logic [EVT_W-1:0] DECIDE_IDX = EVT_W'(3);

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [BLK_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W+1)'(b);
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic [EVT_W-1:0] sat_inc(input logic [EVT_W-1:0] a);
        return (a == {EVT_W{1'b1}}) ? a : a + EVT_W'(1);
    endfunction

    logic             r_active;
    logic [EVT_W-1:0] r_count;
    logic [PH_W-1:0]  r_phase;
    logic             r_dist_pos;
    logic [1:0]       r_low;
    logic [OBS_W-1:0] r_obs;
    logic [OBS_W-1:0] r_rej;
    logic [CNT_W-1:0] r_sum_filt;
    logic [CNT_W-1:0] r_sum_ver;
    logic [CNT_W-1:0] r_sum_miss;
    logic [EVT_W-1:0] r_sum_sw;
    logic [EVT_W-1:0] r_sum_probe;
    logic [CNT_W-1:0] r_sum_hits;

    logic             n_active;
    logic [EVT_W-1:0] n_count;
    logic [PH_W-1:0]  n_phase;
    logic             n_dist_pos;
    logic [1:0]       n_low;
    logic [OBS_W-1:0] n_obs;
    logic [OBS_W-1:0] n_rej;
    logic [CNT_W-1:0] n_sum_filt;
    logic [CNT_W-1:0] n_sum_ver;
    logic [CNT_W-1:0] n_sum_miss;
    logic [EVT_W-1:0] n_sum_sw;
    logic [EVT_W-1:0] n_sum_probe;
    logic [CNT_W-1:0] n_sum_hits;

    logic             clr;
    logic             c_active;
    logic [EVT_W-1:0] c_count;
    logic [PH_W-1:0]  c_phase;
    logic             c_dist_pos;
    logic [1:0]       c_low;
    logic [OBS_W-1:0] c_obs;
    logic [OBS_W-1:0] c_rej;
    logic [CNT_W-1:0] c_sum_filt;
    logic [CNT_W-1:0] c_sum_ver;
    logic [CNT_W-1:0] c_sum_miss;
    logic [EVT_W-1:0] c_sum_sw;
    logic [EVT_W-1:0] c_sum_probe;
    logic [CNT_W-1:0] c_sum_hits;

    logic [BLK_W-1:0]   rows;
    logic [BLK_W-1:0]   pass;
    logic [BLK_W-1:0]   rej;
    logic               periodic;
    logic               probe;
    logic               filt;
    logic               early;
    logic               count_max;
    logic [OBS_W+4:0]   rej_scaled;
    logic               prefix_off;
    logic               per_blk;
    logic [BLK_W+2:0]   rej_x5;
    logic [BLK_W+2:0]   rows_ext;
    logic               enable;
    logic               low_hit;
    logic [1:0]         low_inc;
    logic               disable_now;
    logic               switch_evt;

    always_comb begin
        clr         = i_beat.first_block;
        c_active    = clr ? (i_ctl.mode != MODE_DIRECT) : r_active;
        c_count     = clr ? '0 : r_count;
        c_phase     = clr ? '0 : r_phase;
        c_dist_pos  = clr ? 1'b0 : r_dist_pos;
        c_low       = clr ? '0 : r_low;
        c_obs       = clr ? '0 : r_obs;
        c_rej       = clr ? '0 : r_rej;
        c_sum_filt  = clr ? '0 : r_sum_filt;
        c_sum_ver   = clr ? '0 : r_sum_ver;
        c_sum_miss  = clr ? '0 : r_sum_miss;
        c_sum_sw    = clr ? '0 : r_sum_sw;
        c_sum_probe = clr ? '0 : r_sum_probe;
        c_sum_hits  = clr ? '0 : r_sum_hits;

        rows = (i_beat.block_rows > ROWS_CAP) ? ROWS_CAP : i_beat.block_rows;
        pass = (i_beat.block_passes > rows) ? rows : i_beat.block_passes;
        rej  = rows - pass;

        periodic  = (i_ctl.mode == MODE_PERIODIC);
        probe     = periodic && !c_active && c_dist_pos && (c_phase == '0);
        filt      = c_active || probe;
        early     = (c_count[EVT_W-1:2] == '0);
        count_max = (c_count == {EVT_W{1'b1}});

        n_obs = (early && filt) ? c_obs + OBS_W'(rows) : c_obs;
        n_rej = (early && filt) ? c_rej + OBS_W'(rej) : c_rej;

        case (i_ctl.mode)
            MODE_PREFIX_20: rej_scaled = {1'b0, n_rej, 4'b0} + {3'b0, n_rej, 2'b0};
            MODE_PREFIX_2:  rej_scaled = {4'b0, n_rej, 1'b0};
            default:        rej_scaled = {3'b0, n_rej, 2'b0} + {5'b0, n_rej};
        endcase

        prefix_off = (c_count == DECIDE_IDX) && (i_ctl.mode >= MODE_PREFIX_20) &&
                     (n_obs != '0) && (rej_scaled < (OBS_W+5)'(n_obs));
        per_blk    = periodic && !early && filt;

        rej_x5   = {rej, 2'b0} + (BLK_W+3)'(rej);
        rows_ext = (BLK_W+3)'(rows);
        enable   = probe && (rows != '0) && (rej_x5 >= {rows_ext[BLK_W+1:0], 1'b0});
        low_hit  = (rows != '0) && (rej_x5 < rows_ext);
        low_inc  = c_low + 2'd1;

        n_active    = c_active;
        n_low       = c_low;
        disable_now = 1'b0;
        switch_evt  = 1'b0;
        if (prefix_off) begin
            n_active    = 1'b0;
            disable_now = 1'b1;
            switch_evt  = 1'b1;
        end else if (per_blk) begin
            if (probe) begin
                if (enable) begin
                    n_active   = 1'b1;
                    n_low      = '0;
                    switch_evt = 1'b1;
                end
            end else begin
                n_low = low_hit ? low_inc : 2'd0;
                if (n_low >= 2'd2) begin
                    n_active    = 1'b0;
                    n_low       = '0;
                    disable_now = 1'b1;
                    switch_evt  = 1'b1;
                end
            end
        end

        n_count = count_max ? c_count : c_count + EVT_W'(1);
        if (disable_now) begin
            n_phase    = count_max ? '0 : PH_ONE;
            n_dist_pos = !count_max;
        end else if (!count_max) begin
            n_phase    = (c_phase == PH_LAST) ? '0 : c_phase + PH_W'(1);
            n_dist_pos = 1'b1;
        end else begin
            n_phase    = c_phase;
            n_dist_pos = c_dist_pos;
        end

        if (filt) begin
            n_sum_filt  = sat_add(c_sum_filt, rows);
            n_sum_ver   = sat_add(c_sum_ver, pass);
            n_sum_miss  = c_sum_miss;
            n_sum_probe = probe ? sat_inc(c_sum_probe) : c_sum_probe;
        end else begin
            n_sum_filt  = c_sum_filt;
            n_sum_ver   = sat_add(c_sum_ver, rows);
            n_sum_miss  = sat_add(c_sum_miss, rej);
            n_sum_probe = c_sum_probe;
        end
        n_sum_hits = sat_add(c_sum_hits, i_beat.block_hits);
        n_sum_sw   = switch_evt ? sat_inc(c_sum_sw) : c_sum_sw;

        o_result.filtered            = filt;
        o_result.probed              = probe;
        o_result.switched            = (c_active != n_active);
        o_result.active_after        = n_active;
        o_result.total_filtered_rows = n_sum_filt;
        o_result.total_verify_calls  = n_sum_ver;
        o_result.total_missed        = n_sum_miss;
        o_result.total_switches      = n_sum_sw;
        o_result.total_probes        = n_sum_probe;
        o_result.total_verified_hits = n_sum_hits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.restart) begin
            r_active    <= i_rst_n ? (i_ctl.mode != MODE_DIRECT) : 1'b0;
            r_count     <= '0;
            r_phase     <= '0;
            r_dist_pos  <= 1'b0;
            r_low       <= '0;
            r_obs       <= '0;
            r_rej       <= '0;
            r_sum_filt  <= '0;
            r_sum_ver   <= '0;
            r_sum_miss  <= '0;
            r_sum_sw    <= '0;
            r_sum_probe <= '0;
            r_sum_hits  <= '0;
        end else if (i_fire) begin
            r_active    <= n_active;
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_dist_pos  <= n_dist_pos;
            r_low       <= n_low;
            r_obs       <= n_obs;
            r_rej       <= n_rej;
            r_sum_filt  <= n_sum_filt;
            r_sum_ver   <= n_sum_ver;
            r_sum_miss  <= n_sum_miss;
            r_sum_sw    <= n_sum_sw;
            r_sum_probe <= n_sum_probe;
            r_sum_hits  <= n_sum_hits;
        end
    end

endmodule

// File: rtl/adaptive_prefilter_bypass_controller.sv
// Top level of the adaptive prefilter bypass controller: handshake, register port, result stage.
//
//  channel   direction  handshake                     payload
//  in        input      i_in_valid / o_in_stall       i_in_beat  (t_in_beat)
//  out       output     o_out_valid / i_out_stall     o_out_beat (t_out_beat)
//  config    input      psel penable pwrite pready    paddr pwdata prdata
//
// One beat per cycle sustained while the output is not stalled; an accepted beat is
// registered in the input register and then in the result register around the decision logic.
// Synchronous active-low reset puts the policy in direct mode with all totals at zero.
// A stall on the output holds the result register and, once the input register is
// also full, stalls the input. A policy write restarts the sequence.
module adaptive_prefilter_bypass_controller
    import apbc_pkg::*;
#(
    parameter int MAX_BLOCK_ROWS = DEF_MAX_BLOCK_ROWS,
    parameter int PROBE_PERIOD   = DEF_PROBE_PERIOD
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_beat         o_out_beat,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic              r_in_valid;
    t_in_beat          r_in;
    logic              r_out_valid;
    t_out_beat         r_out;
    logic [MODE_W-1:0] r_mode;

    logic      out_free;
    logic      fire;
    logic      accept;
    logic      cfg_wr;
    t_seq_ctl  ctl;
    t_out_beat result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POLICY_MODE);
    assign prdata = (paddr[2] == REG_POLICY_MODE) ? DATA_W'(r_mode) : '0;

    assign ctl.restart = cfg_wr;
    assign ctl.mode    = cfg_wr ? pwdata[MODE_W-1:0] : r_mode;

    apbc_step #(
        .MAX_BLOCK_ROWS(MAX_BLOCK_ROWS),
        .PROBE_PERIOD  (PROBE_PERIOD)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_beat  (r_in),
        .i_ctl   (ctl),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DIRECT;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_mode <= pwdata[MODE_W-1:0];
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_beat;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule
